// ----- sv/response_frame_deframer_defines.svh -----
// ----------------------------------------------------------------------------
// Response frame deframer: shared assertion macros
// Clocked, reset-gated concurrent assertion helpers for the deframer RTL.
// ----------------------------------------------------------------------------
`ifndef RESPONSE_FRAME_DEFRAMER_DEFINES_SVH
`define RESPONSE_FRAME_DEFRAMER_DEFINES_SVH

// Assertion on an explicit clock and active-low reset.
`define RFD_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Assertion on the block clock and reset.
`define RFD_ASSERT(lbl, prop, msg) \
  `RFD_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

// ----- sv/rfd_pkg.sv -----
// ----------------------------------------------------------------------------
// Response frame deframer package
// Types and constants shared by the parser and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package rfd_pkg;

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_LENGTH  = 2'd1,
    PH_PAYLOAD = 2'd2,
    PH_RSVD    = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    KIND_CMP = 2'd0,
    KIND_ERR = 2'd1,
    KIND_PKT = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    EV_DATA = 2'd0,
    EV_END  = 2'd1,
    EV_BAD  = 2'd2
  } event_e;

  localparam logic [1:0]  IDX_LAST  = 2'd3;
  localparam logic [23:0] TOKEN_CMP = 24'h434D50;
  localparam logic [23:0] TOKEN_ERR = 24'h455252;
  localparam logic [23:0] TOKEN_PKT = 24'h504B54;

  typedef struct packed {
    logic       valid;
    event_e     ev;
    logic [7:0] data;
    logic       kind;
    logic       last;
  } res_t;

endpackage

`default_nettype wire

// ----- sv/rfd_parser.sv -----
// ----------------------------------------------------------------------------
// Response frame deframer: frame parser
// Header/length/payload state machine; one byte per step, at most one result.
// ----------------------------------------------------------------------------
`default_nettype none

`include "response_frame_deframer_defines.svh"

module rfd_parser (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        step_i,
  input  wire logic [7:0]  byte_i,
  output rfd_pkg::res_t    res_o
);
  import rfd_pkg::*;

  phase_e      phase_q, phase_d;
  logic [1:0]  byte_idx_q, byte_idx_d;
  logic [23:0] token_q, token_d;
  kind_e       kind_q, kind_d;
  logic [31:0] len_q, len_d;
  logic [31:0] rem_q, rem_d;

  always_comb begin
    phase_d    = phase_q;
    byte_idx_d = byte_idx_q;
    token_d    = token_q;
    kind_d     = kind_q;
    len_d      = len_q;
    rem_d      = rem_q;
    res_o      = '0;

    unique case (phase_q)
      PH_LENGTH: begin
        len_d = {len_q[23:0], byte_i};
        if (byte_idx_q != IDX_LAST) begin
          byte_idx_d = byte_idx_q + 2'd1;
        end else begin
          byte_idx_d = '0;
          if (len_d != '0) begin
            rem_d   = len_d;
            phase_d = PH_PAYLOAD;
          end else begin
            phase_d = PH_HEADER;
            if (kind_q != KIND_PKT) begin
              res_o.valid = 1'b1;
              res_o.ev    = EV_END;
              res_o.kind  = (kind_q == KIND_ERR);
              res_o.last  = 1'b1;
            end
          end
        end
      end
      PH_PAYLOAD: begin
        rem_d = rem_q - 32'd1;
        if (rem_d == '0) phase_d = PH_HEADER;
        if (kind_q != KIND_PKT) begin
          res_o.valid = 1'b1;
          res_o.ev    = EV_DATA;
          res_o.data  = byte_i;
          res_o.kind  = (kind_q == KIND_ERR);
          res_o.last  = (rem_d == '0);
        end
      end
      default: begin
        // header hunt; the unused phase code behaves the same
        phase_d = PH_HEADER;
        if (byte_idx_q != IDX_LAST) begin
          token_d    = {token_q[15:0], byte_i};
          byte_idx_d = byte_idx_q + 2'd1;
        end else begin
          byte_idx_d = '0;
          priority if (token_q == TOKEN_CMP) begin
            kind_d  = KIND_CMP;
            len_d   = '0;
            phase_d = PH_LENGTH;
          end else if (token_q == TOKEN_ERR) begin
            kind_d  = KIND_ERR;
            len_d   = '0;
            phase_d = PH_LENGTH;
          end else if (token_q == TOKEN_PKT) begin
            kind_d  = KIND_PKT;
            len_d   = '0;
            phase_d = PH_LENGTH;
          end else begin
            // drop the frame and keep hunting
            res_o.valid = 1'b1;
            res_o.ev    = EV_BAD;
            res_o.last  = 1'b1;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_HEADER;
      byte_idx_q <= '0;
      token_q    <= '0;
      kind_q     <= KIND_CMP;
      len_q      <= '0;
      rem_q      <= '0;
    end else if (step_i) begin
      phase_q    <= phase_d;
      byte_idx_q <= byte_idx_d;
      token_q    <= token_d;
      kind_q     <= kind_d;
      len_q      <= len_d;
      rem_q      <= rem_d;
    end
  end

  `RFD_ASSERT(a_payload_count_nonzero, (phase_q == PH_PAYLOAD) |-> (rem_q != '0), "payload phase with zero count")
  `RFD_ASSERT(a_last_byte_ends_frame, (step_i && phase_q == PH_PAYLOAD && rem_q == 32'd1) |=> (phase_q == PH_HEADER), "frame did not end after last byte")
  `RFD_ASSERT(a_bad_token_in_header, (step_i && res_o.valid && res_o.ev == EV_BAD) |-> (byte_idx_q == IDX_LAST && phase_q != PH_LENGTH && phase_q != PH_PAYLOAD), "bad token outside header")
  `RFD_ASSERT(a_length_starts_clean, (step_i && phase_q != PH_LENGTH && phase_q != PH_PAYLOAD && byte_idx_q == IDX_LAST && !res_o.valid) |=> (phase_q == PH_LENGTH && len_q == '0), "length phase entered unclean")

endmodule

`default_nettype wire

// ----- sv/response_frame_deframer.sv -----
// ----------------------------------------------------------------------------
// Response frame deframer
// Splits the response byte stream into CMP/ERR results and bad-token events.
// ----------------------------------------------------------------------------
//  Channel  Dir  Handshake                  Payload
//  in       in   in_valid_i / in_ready_o    in_byte_i
//  out      out  out_valid_o / out_ready_i  event_res_o, data_byte_o,
//                                           frame_kind_o, last_o
//
// One byte per cycle sustained while out_ready_i stays high; a result passes
// through the input register and then the result register to the outputs.
// Rate is set by the parser state update, which takes one byte per advance.
// A held result also holds the staged byte; an empty input reg can still load.
// Reset puts the parser in header hunt with all counters cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module response_frame_deframer (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] in_byte_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [1:0]      event_res_o,
  output logic [7:0]      data_byte_o,
  output logic            frame_kind_o,
  output logic            last_o
);
  import rfd_pkg::*;

  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       out_valid_q;
  logic [1:0] event_q;
  logic [7:0] data_q;
  logic       kind_q;
  logic       last_q;
  logic       advance;
  res_t       res;

  // advance the staged byte once the result slot is free or draining
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  rfd_parser u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .byte_i (in_byte_q),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) in_byte_q <= in_byte_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && res.valid) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res.valid) begin
      event_q <= res.ev;
      data_q  <= res.data;
      kind_q  <= res.kind;
      last_q  <= res.last;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign event_res_o  = event_q;
  assign data_byte_o  = data_q;
  assign frame_kind_o = kind_q;
  assign last_o       = last_q;

endmodule

`default_nettype wire
